>>> design/awn_pkg.sv
// ============================================================================
// awn_pkg
// Shared widths, register codes and reset values of the affine warp unit.
// ============================================================================
package awn_pkg;

   // Default frame store dimensions.
   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 256;

   // Field and arithmetic widths.
   localparam int PIX_W   = 8;                    // one color channel, one coordinate
   localparam int RGB_W   = 3 * PIX_W;
   localparam int COEF_W  = 32;                   // signed Q15.16 coefficient
   localparam int DIM_W   = 9;                    // image_width / image_height
   localparam int FRAC_W  = 16;
   localparam int PROD_W  = COEF_W + PIX_W + 1;   // coefficient times unsigned 8-bit
   localparam int SUM_W   = PROD_W + 1;           // two products plus an offset
   localparam int INT_W   = SUM_W - FRAC_W;       // integer part of a sum
   localparam int FRAC_MASK = (1 << FRAC_W) - 1;

   // Request packing.
   localparam int REQ_DATA_W = 5 * PIX_W;
   localparam int RSP_DATA_W = RGB_W;

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = COEF_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COEF_X_COL   = 3'd0,
      CSR_COEF_X_ROW   = 3'd1,
      CSR_OFFSET_X     = 3'd2,
      CSR_COEF_Y_COL   = 3'd3,
      CSR_COEF_Y_ROW   = 3'd4,
      CSR_OFFSET_Y     = 3'd5,
      CSR_IMAGE_WIDTH  = 3'd6,
      CSR_IMAGE_HEIGHT = 3'd7
   } csr_index_type;

   // Command carried in req_tuser.
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_FETCH = 1'b1;

   // Reset values: identity mapping over a full 256 x 256 frame.
   localparam logic signed [COEF_W-1:0] RST_COEF_ONE  = 32'sd65536;
   localparam logic signed [COEF_W-1:0] RST_COEF_ZERO = 32'sd0;
   localparam logic [DIM_W-1:0]         RST_DIM       = 9'd256;

endpackage

>>> design/affine_warp_nearest_unit.sv
// ============================================================================
// affine_warp_nearest_unit
// Inverse-mapping affine warp with nearest-neighbor sampling of an RGB frame.
// ============================================================================
// The unit takes one transfer per clock on the request side while req_tready
// is high. A load (tuser 0) writes one RGB pixel into the frame store at
// (row, col); a fetch (tuser 1) maps the destination (row, col) through the
// six Q15.16 coefficients, truncates toward zero and returns the stored pixel,
// or black with the outside flag set. Only fetches produce a response. The
// pipeline has four register stages (input, products, sums, store read), and
// one item per cycle is sustained while the response side is not stalled; the
// single port of the frame store is used once per item in the third stage,
// for the write of a load or the read of a fetch. Each stage holds only when
// the stage after it is full, and a load in the third stage passes even when
// a response is waiting. Reading a pixel that was never loaded returns an
// undefined value. Coefficients may be changed only while the unit is empty.
// ============================================================================
module affine_warp_nearest_unit
   import awn_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                   clock,
   input  logic                   reset,
   // Request channel.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // pixel_row, pixel_col, load_red,
                                               // load_green, load_blue
   input  logic                   req_tuser,   // command
   // Response channel.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // out_red, out_green, out_blue
   output logic                   rsp_tuser,   // outside
   // Configuration write port.
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int X_W    = $clog2(MAX_WIDTH);
   localparam int Y_W    = $clog2(MAX_HEIGHT);

   // ------------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------------
   logic signed [COEF_W-1:0] coef_x_col_ff, coef_x_row_ff, offset_x_ff;
   logic signed [COEF_W-1:0] coef_y_col_ff, coef_y_row_ff, offset_y_ff;
   logic [DIM_W-1:0]         image_width_ff, image_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_x_col_ff   <= RST_COEF_ONE;
         coef_x_row_ff   <= RST_COEF_ZERO;
         offset_x_ff     <= RST_COEF_ZERO;
         coef_y_col_ff   <= RST_COEF_ZERO;
         coef_y_row_ff   <= RST_COEF_ONE;
         offset_y_ff     <= RST_COEF_ZERO;
         image_width_ff  <= RST_DIM;
         image_height_ff <= RST_DIM;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_COEF_X_COL:   coef_x_col_ff   <= csr_wdata;
            CSR_COEF_X_ROW:   coef_x_row_ff   <= csr_wdata;
            CSR_OFFSET_X:     offset_x_ff     <= csr_wdata;
            CSR_COEF_Y_COL:   coef_y_col_ff   <= csr_wdata;
            CSR_COEF_Y_ROW:   coef_y_row_ff   <= csr_wdata;
            CSR_OFFSET_Y:     offset_y_ff     <= csr_wdata;
            CSR_IMAGE_WIDTH:  image_width_ff  <= csr_wdata[DIM_W-1:0];
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_wdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Stage handshake
   // ------------------------------------------------------------------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   logic s1_fetch_ff, s2_fetch_ff, s3_fetch_ff;
   logic s1_ready, s2_ready, s3_ready, s4_ready;

   assign s4_ready   = !rsp_valid_ff || rsp_tready;
   // A load in stage 3 never fills the response register, so it need not wait.
   assign s3_ready   = !s3_valid_ff || !s3_fetch_ff || s4_ready;
   assign s2_ready   = !s2_valid_ff || s3_ready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign req_tready = s1_ready;

   // ------------------------------------------------------------------------
   // Stage 1: input register
   // ------------------------------------------------------------------------
   logic [PIX_W-1:0] s1_row_ff, s1_col_ff;
   logic [RGB_W-1:0] s1_rgb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && req_tvalid) begin
         s1_fetch_ff <= (req_tuser == CMD_FETCH);
         s1_row_ff   <= req_tdata[PIX_W-1:0];
         s1_col_ff   <= req_tdata[2*PIX_W-1:PIX_W];
         // Stored as red in the top byte, blue in the bottom byte.
         s1_rgb_ff   <= {req_tdata[3*PIX_W-1:2*PIX_W], req_tdata[4*PIX_W-1:3*PIX_W],
                         req_tdata[5*PIX_W-1:4*PIX_W]};
      end
   end

   // ------------------------------------------------------------------------
   // Stage 2: products of the coefficients with the destination coordinates
   // ------------------------------------------------------------------------
   logic signed [PROD_W-1:0] s2_pxc_in, s2_pxr_in, s2_pyc_in, s2_pyr_in;
   logic signed [PROD_W-1:0] s2_pxc_ff, s2_pxr_ff, s2_pyc_ff, s2_pyr_ff;
   logic [PIX_W-1:0]         s2_row_ff, s2_col_ff;
   logic [RGB_W-1:0]         s2_rgb_ff;

   always_comb begin
      s2_pxc_in = coef_x_col_ff * $signed({1'b0, s1_col_ff});
      s2_pxr_in = coef_x_row_ff * $signed({1'b0, s1_row_ff});
      s2_pyc_in = coef_y_col_ff * $signed({1'b0, s1_col_ff});
      s2_pyr_in = coef_y_row_ff * $signed({1'b0, s1_row_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         s2_pxc_ff   <= s2_pxc_in;
         s2_pxr_ff   <= s2_pxr_in;
         s2_pyc_ff   <= s2_pyc_in;
         s2_pyr_ff   <= s2_pyr_in;
         s2_fetch_ff <= s1_fetch_ff;
         s2_row_ff   <= s1_row_ff;
         s2_col_ff   <= s1_col_ff;
         s2_rgb_ff   <= s1_rgb_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 3: exact Q25.16 source coordinates
   // ------------------------------------------------------------------------
   logic signed [SUM_W-1:0] s3_sx_in, s3_sy_in, s3_sx_ff, s3_sy_ff;
   logic [PIX_W-1:0]        s3_row_ff, s3_col_ff;
   logic [RGB_W-1:0]        s3_rgb_ff;

   always_comb begin
      s3_sx_in = SUM_W'(s2_pxc_ff) + SUM_W'(s2_pxr_ff) + SUM_W'(offset_x_ff);
      s3_sy_in = SUM_W'(s2_pyc_ff) + SUM_W'(s2_pyr_ff) + SUM_W'(offset_y_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_ready) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready && s2_valid_ff) begin
         s3_sx_ff    <= s3_sx_in;
         s3_sy_ff    <= s3_sy_in;
         s3_fetch_ff <= s2_fetch_ff;
         s3_row_ff   <= s2_row_ff;
         s3_col_ff   <= s2_col_ff;
         s3_rgb_ff   <= s2_rgb_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 3 logic: truncation, frame test and store address
   // ------------------------------------------------------------------------
   logic signed [SUM_W-1:0] x_bias, y_bias;
   logic [INT_W-1:0]        x_int, y_int, w_lim, h_lim, w_cfg, h_cfg;
   logic                    in_frame, load_ok;
   logic [X_W-1:0]          x_idx;
   logic [Y_W-1:0]          y_idx;
   logic [ADDR_W-1:0]       mem_addr;
   logic                    mem_we, mem_re;

   always_comb begin
      // A sum at or below -1.0 leaves a negative integer; adding 0xFFFF shows it
      // in the sign bit. Sums in (-1.0, 0) truncate to zero.
      x_bias = s3_sx_ff + SUM_W'(FRAC_MASK);
      y_bias = s3_sy_ff + SUM_W'(FRAC_MASK);
      x_int  = s3_sx_ff[SUM_W-1] ? '0 : s3_sx_ff[SUM_W-1:FRAC_W];
      y_int  = s3_sy_ff[SUM_W-1] ? '0 : s3_sy_ff[SUM_W-1:FRAC_W];

      w_cfg  = INT_W'(image_width_ff);
      h_cfg  = INT_W'(image_height_ff);
      w_lim  = (w_cfg > INT_W'(MAX_WIDTH))  ? INT_W'(MAX_WIDTH)  : w_cfg;
      h_lim  = (h_cfg > INT_W'(MAX_HEIGHT)) ? INT_W'(MAX_HEIGHT) : h_cfg;

      in_frame = !x_bias[SUM_W-1] && !y_bias[SUM_W-1] && (x_int < w_lim) && (y_int < h_lim);
      load_ok  = (INT_W'(s3_row_ff) < INT_W'(MAX_HEIGHT))
                 && (INT_W'(s3_col_ff) < INT_W'(MAX_WIDTH));

      if (s3_fetch_ff) begin
         x_idx = X_W'(x_int);
         y_idx = Y_W'(y_int);
      end else begin
         x_idx = X_W'(s3_col_ff);
         y_idx = Y_W'(s3_row_ff);
      end
      mem_addr = ADDR_W'(y_idx) * ADDR_W'(MAX_WIDTH) + ADDR_W'(x_idx);

      mem_we = s3_valid_ff && !s3_fetch_ff && load_ok;
      mem_re = s3_valid_ff && s3_fetch_ff && s4_ready && in_frame;
   end

   // ------------------------------------------------------------------------
   // Frame store and response register
   // ------------------------------------------------------------------------
   logic [RGB_W-1:0] frame_mem [DEPTH];
   logic [RGB_W-1:0] rd_pix_ff;
   logic             rsp_outside_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[mem_addr] <= s3_rgb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_pix_ff <= frame_mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s4_ready) begin
         rsp_valid_ff <= s3_valid_ff && s3_fetch_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s4_ready && s3_valid_ff && s3_fetch_ff) begin
         rsp_outside_ff <= !in_frame;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_outside_ff;
   assign rsp_tdata  = rsp_outside_ff ? '0
                     : {rd_pix_ff[PIX_W-1:0], rd_pix_ff[2*PIX_W-1:PIX_W],
                        rd_pix_ff[3*PIX_W-1:2*PIX_W]};

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   // A fetch leaving stage 3 always shows up as a response.
   a_fetch_responds: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && s3_fetch_ff && s3_ready) |=> rsp_tvalid)
      else $error("fetch leaving stage 3 did not produce a response");

   // A load leaving stage 3 never creates a response.
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && !s3_fetch_ff && (!rsp_valid_ff || rsp_tready)) |=> !rsp_tvalid)
      else $error("load produced a response");

   // A point at or below -1.0 in x is reported outside.
   a_negative_outside: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && s3_fetch_ff && s4_ready && x_bias[SUM_W-1]) |=> rsp_tuser)
      else $error("negative source column reported inside");

   // Stage 2 holds its products while stage 3 is blocked.
   a_stage2_hold: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !s3_ready) |=> (s2_valid_ff && $stable(s2_pxc_ff)
                                      && $stable(s2_pyr_ff)))
      else $error("stage 2 changed while stalled");

endmodule
